>>> rtl/core/sfc_pkg.sv
// shared types, constants and crc helper for the scope frame encoder
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int BYTE_W      = 8;
  localparam int NUM_CH      = 4;
  localparam int DATA_BYTES  = 8;
  localparam int FRAME_BYTES = 10;
  localparam int IDX_W       = 4;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // byte positions inside the frame
  localparam logic [IDX_W-1:0] IDX_FIRST  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_CRC_LO = 4'd8;
  localparam logic [IDX_W-1:0] IDX_CRC_HI = 4'd9;

  typedef logic [NUM_CH*SAMPLE_W-1:0] frame_data_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  // reflected crc-16 update over one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/sfc_queue.sv
// front part: takes sample words and holds them until the serializer is free
`timescale 1ns / 1ps

module sfc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfc_pkg::frame_data_t push_data,
  input  logic                 pop,
  output sfc_pkg::frame_data_t head,
  output sfc_pkg::q_status_t   status
);

  sfc_pkg::frame_data_t entries [sfc_pkg::Q_DEPTH];
  logic [sfc_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [sfc_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [sfc_pkg::Q_CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.full      = (count == sfc_pkg::Q_CNT_W'(sfc_pkg::Q_DEPTH));
  assign status.not_empty = (count != '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && status.not_empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sfc_pkg::Q_PTR_W'(sfc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sfc_pkg::Q_PTR_W'(sfc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/sfc_back.sv
// back part: serializes one sample word into ten frame bytes with running crc
`timescale 1ns / 1ps

module sfc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sfc_pkg::q_status_t        q_status,
  input  sfc_pkg::frame_data_t      head,
  output logic                      pop,
  output logic                      byte_strobe,
  output logic [sfc_pkg::BYTE_W-1:0] frame_byte,
  output logic                      frame_end
);

  logic                         active;
  logic [sfc_pkg::IDX_W-1:0]    idx;
  sfc_pkg::frame_data_t         data;
  logic [15:0]                  crc;

  logic last;
  logic load;

  assign last = active && (idx == sfc_pkg::IDX_CRC_HI);
  assign load = (!active || last) && q_status.not_empty;
  assign pop  = load;

  assign byte_strobe = active;
  assign frame_end   = last;

  always_comb begin
    case (idx)
      sfc_pkg::IDX_CRC_LO: frame_byte = crc[7:0];
      sfc_pkg::IDX_CRC_HI: frame_byte = crc[15:8];
      default:             frame_byte = data[sfc_pkg::BYTE_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= head;
      crc  <= sfc_pkg::CRC_INIT;
    end else if (active && idx < sfc_pkg::IDX_CRC_LO) begin
      data <= data >> sfc_pkg::BYTE_W;
      crc  <= sfc_pkg::crc16_byte(crc, data[sfc_pkg::BYTE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= sfc_pkg::IDX_FIRST;
    end else if (load) begin
      active <= 1'b1;
      idx    <= sfc_pkg::IDX_FIRST;
    end else if (last) begin
      active <= 1'b0;
      idx    <= sfc_pkg::IDX_FIRST;
    end else if (active) begin
      idx    <= idx + 1'b1;
    end
  end

endmodule

>>> rtl/core/scope_frame_crc16_encoder.sv
// top level: four-channel scope frame encoder with crc-16/modbus trailer
`timescale 1ns / 1ps
// the first byte of a frame is on the ports once its word has been written into
//   the queue and then loaded into the serializer
// output: one byte per cycle while a frame is going out, ten bytes per frame,
//   set by the single byte output of the serializer
// a two-entry queue lets words be taken while a frame is going out
// reset (synchronous, active high) empties the queue and idles the serializer

module scope_frame_crc16_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] sample_a,
  input  logic [15:0] sample_b,
  input  logic [15:0] sample_c,
  input  logic [15:0] sample_d,
  output logic        byte_strobe,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);

  sfc_pkg::frame_data_t word_in;
  sfc_pkg::frame_data_t q_head;
  sfc_pkg::q_status_t   q_status;
  logic                 q_pop;
  logic                 accept;

  // low byte of sample a goes out first, so it sits at the bottom
  assign word_in = {sample_d, sample_c, sample_b, sample_a};

  // busy only when both queue slots hold words
  assign busy   = q_status.full;
  assign accept = start && !busy;

  sfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (word_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // serializer: eight data bytes feed the crc, then crc low and high
  sfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (q_head),
    .pop         (q_pop),
    .byte_strobe (byte_strobe),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end)
  );

  // end of frame only on a strobed byte
  assert property (@(posedge clk) disable iff (rst) frame_end |-> byte_strobe)
    else $error("frame_end without byte_strobe");

  // bytes of one frame come out without gaps
  assert property (@(posedge clk) disable iff (rst)
    (byte_strobe && !frame_end) |=> byte_strobe)
    else $error("gap inside a frame");

  // two frame ends are never adjacent
  assert property (@(posedge clk) disable iff (rst) frame_end |=> !frame_end)
    else $error("frame shorter than ten bytes");

  // a frame starting from idle never begins with its last byte
  assert property (@(posedge clk) disable iff (rst) $rose(byte_strobe) |-> !frame_end)
    else $error("frame started on its last byte");

endmodule
